[hw/rtl/dmtb_pkg.sv]
// ----------------------------------------------------------------------------
// Dot-matrix text buffer package
// Command codes, fixed sizes and the beat structures shared by the buffer
// core and its command engine.
// ----------------------------------------------------------------------------
package dmtb_pkg;

    localparam int GLYPH_COUNT     = 128;
    localparam int ROW_COUNT       = 8;
    localparam int FONT_DEPTH      = GLYPH_COUNT * ROW_COUNT;
    localparam int FONT_ADDR_W     = $clog2(FONT_DEPTH);
    localparam int ROW_BYTES_RESET = 8;

    localparam logic [2:0] CMD_LOAD_FONT = 3'd0;
    localparam logic [2:0] CMD_DRAW      = 3'd1;
    localparam logic [2:0] CMD_ROT_LEFT  = 3'd2;
    localparam logic [2:0] CMD_ROT_RIGHT = 3'd3;
    localparam logic [2:0] CMD_CLEAR     = 3'd4;
    localparam logic [2:0] CMD_READ      = 3'd5;

    localparam logic [6:0] QMARK_CODE = 7'h3F;
    localparam logic [3:0] SHIFT_MAX  = 4'd8;
    localparam logic [2:0] LAST_ROW   = 3'd7;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] dot_column;
        logic [7:0] char_code;
        logic [2:0] row_index;
        logic [4:0] byte_index;
        logic [7:0] data_byte;
        logic [3:0] shift_amount;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       ignored;
    } res_t;

endpackage

[hw/rtl/dmtb_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dmtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/dmtb_engine.sv]
// ----------------------------------------------------------------------------
// Dot-matrix text buffer command engine
// Sequences one command at a time over the font and dot memories: font
// loads, glyph merges, row rotation, clearing sweeps and byte reads.
// ----------------------------------------------------------------------------
module dmtb_engine #(
    parameter int MAX_ROW_BYTES = 32,
    localparam int DOT_DEPTH  = dmtb_pkg::ROW_COUNT * MAX_ROW_BYTES,
    localparam int DOT_ADDR_W = $clog2(DOT_DEPTH)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  dmtb_pkg::cmd_t                     cmd,
    output logic                               idle,
    input  logic [5:0]                         row_bytes,
    output logic                               font_we,
    output logic [dmtb_pkg::FONT_ADDR_W-1:0]   font_waddr,
    output logic [7:0]                         font_wdata,
    output logic [dmtb_pkg::FONT_ADDR_W-1:0]   font_raddr,
    input  logic [7:0]                         font_rdata,
    output logic                               dot_we,
    output logic [DOT_ADDR_W-1:0]              dot_waddr,
    output logic [7:0]                         dot_wdata,
    output logic [DOT_ADDR_W-1:0]              dot_raddr,
    input  logic [7:0]                         dot_rdata,
    output logic                               res_valid,
    output dmtb_pkg::res_t                     res,
    input  logic                               res_ready
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLEAR   = 4'd1;
    localparam logic [3:0] S_READ    = 4'd2;
    localparam logic [3:0] S_DRAW_A  = 4'd3;
    localparam logic [3:0] S_DRAW_B  = 4'd4;
    localparam logic [3:0] S_DRAW_C  = 4'd5;
    localparam logic [3:0] S_ROT     = 4'd6;
    localparam logic [3:0] S_ROT_FIN = 4'd7;
    localparam logic [3:0] S_RESULT  = 4'd8;

    localparam logic [DOT_ADDR_W-1:0] DOT_LAST = DOT_ADDR_W'(DOT_DEPTH - 1);

    function automatic logic [DOT_ADDR_W-1:0] dot_addr(input logic [2:0] r,
                                                        input logic [5:0] c);
        dot_addr = DOT_ADDR_W'(r) * DOT_ADDR_W'(MAX_ROW_BYTES) + DOT_ADDR_W'(c);
    endfunction

    logic [3:0]            state_reg, state_next;
    logic [DOT_ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic                  clr_cmd_reg, clr_cmd_next;
    logic                  arr_valid_reg, arr_valid_next;
    logic                  fin_valid_reg, fin_valid_next;

    logic [2:0] row_reg, row_next;
    logic [5:0] col_reg, col_next;
    logic [6:0] code_reg, code_next;
    logic [4:0] byte_reg, byte_next;
    logic [2:0] bit_reg, bit_next;
    logic [3:0] shift_reg, shift_next;
    logic       left_reg, left_next;
    logic [7:0] glyph_reg, glyph_next;
    logic [5:0] arr_col_reg, arr_col_next;
    logic [2:0] arr_row_reg, arr_row_next;
    logic [2:0] fin_row_reg, fin_row_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] prev_reg, prev_next;
    logic [7:0] res_data_reg, res_data_next;
    logic       res_ign_reg, res_ign_next;

    logic [15:0] rot_word, rot_shl, rot_shr;
    logic [7:0]  rot_val;
    logic [7:0]  draw_glyph;
    logic [15:0] draw_spread;
    logic [7:0]  keep_mask;
    logic [5:0]  byte_inc;

    assign rot_word    = {prev_reg, fin_valid_reg ? first_reg : dot_rdata};
    assign rot_shl     = rot_word << shift_reg;
    assign rot_shr     = rot_word >> shift_reg;
    assign rot_val     = left_reg ? rot_shl[15:8] : rot_shr[7:0];
    assign draw_glyph  = (state_reg == S_DRAW_B) ? font_rdata : glyph_reg;
    assign draw_spread = {draw_glyph, 8'h00} >> bit_reg;
    assign keep_mask   = 8'hFF >> bit_reg;
    assign byte_inc    = {1'b0, byte_reg} + 6'd1;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        clr_cmd_next   = clr_cmd_reg;
        arr_valid_next = 1'b0;
        fin_valid_next = 1'b0;
        row_next       = row_reg;
        col_next       = col_reg;
        code_next      = code_reg;
        byte_next      = byte_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        left_next      = left_reg;
        glyph_next     = glyph_reg;
        arr_col_next   = col_reg;
        arr_row_next   = row_reg;
        fin_row_next   = row_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        res_data_next  = res_data_reg;
        res_ign_next   = res_ign_reg;

        font_we    = 1'b0;
        font_waddr = {cmd.char_code[6:0], cmd.row_index};
        font_wdata = cmd.data_byte;
        font_raddr = {code_reg, row_reg};
        dot_we     = 1'b0;
        dot_waddr  = '0;
        dot_wdata  = '0;
        dot_raddr  = dot_addr(row_reg, col_reg);

        // rotate: retire the byte that arrives from the read issued last cycle
        if (arr_valid_reg)
        begin
            prev_next = dot_rdata;
            if (arr_col_reg == 6'd0)
            begin
                first_next = dot_rdata;
            end
            else
            begin
                dot_we    = 1'b1;
                dot_waddr = dot_addr(arr_row_reg,
                                     left_reg ? arr_col_reg - 6'd1 : arr_col_reg);
                dot_wdata = rot_val;
            end
        end

        // rotate: close the row with the wrap-around byte
        if (fin_valid_reg)
        begin
            dot_we    = 1'b1;
            dot_waddr = dot_addr(fin_row_reg, left_reg ? row_bytes - 6'd1 : 6'd0);
            dot_wdata = rot_val;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_data_next = 8'h00;
                    res_ign_next  = 1'b0;
                    state_next    = S_RESULT;
                    case (cmd.command)
                        dmtb_pkg::CMD_LOAD_FONT:
                        begin
                            if (cmd.char_code[7])
                            begin
                                res_ign_next = 1'b1;
                            end
                            else
                            begin
                                font_we = 1'b1;
                            end
                        end
                        dmtb_pkg::CMD_DRAW:
                        begin
                            if ({1'b0, cmd.dot_column} >= {row_bytes, 3'b000})
                            begin
                                res_ign_next = 1'b1;
                            end
                            else
                            begin
                                code_next  = cmd.char_code[7] ? dmtb_pkg::QMARK_CODE
                                                              : cmd.char_code[6:0];
                                byte_next  = cmd.dot_column[7:3];
                                bit_next   = cmd.dot_column[2:0];
                                row_next   = 3'd0;
                                state_next = S_DRAW_A;
                            end
                        end
                        dmtb_pkg::CMD_ROT_LEFT, dmtb_pkg::CMD_ROT_RIGHT:
                        begin
                            if (cmd.shift_amount == 4'd0 ||
                                cmd.shift_amount > dmtb_pkg::SHIFT_MAX)
                            begin
                                res_ign_next = 1'b1;
                            end
                            else
                            begin
                                left_next  = (cmd.command == dmtb_pkg::CMD_ROT_LEFT);
                                shift_next = cmd.shift_amount;
                                row_next   = 3'd0;
                                col_next   = 6'd0;
                                state_next = S_ROT;
                            end
                        end
                        dmtb_pkg::CMD_CLEAR:
                        begin
                            clr_addr_next = '0;
                            clr_cmd_next  = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        dmtb_pkg::CMD_READ:
                        begin
                            if ({1'b0, cmd.byte_index} >= row_bytes)
                            begin
                                res_ign_next = 1'b1;
                            end
                            else
                            begin
                                dot_raddr  = dot_addr(cmd.row_index, {1'b0, cmd.byte_index});
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            res_ign_next = 1'b1;
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                dot_we    = 1'b1;
                dot_waddr = clr_addr_reg;
                dot_wdata = 8'h00;
                if (clr_addr_reg == DOT_LAST)
                begin
                    clr_cmd_next = 1'b0;
                    state_next   = clr_cmd_reg ? S_RESULT : S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            S_READ:
            begin
                res_data_next = dot_rdata;
                state_next    = S_RESULT;
            end

            S_DRAW_A:
            begin
                dot_raddr  = dot_addr(row_reg, {1'b0, byte_reg});
                state_next = S_DRAW_B;
            end

            S_DRAW_B:
            begin
                glyph_next = font_rdata;
                dot_we     = 1'b1;
                dot_waddr  = dot_addr(row_reg, {1'b0, byte_reg});
                dot_wdata  = (dot_rdata & ~keep_mask) | draw_spread[15:8];
                if (bit_reg != 3'd0 && byte_inc < row_bytes)
                begin
                    dot_raddr  = dot_addr(row_reg, byte_inc);
                    state_next = S_DRAW_C;
                end
                else if (row_reg == dmtb_pkg::LAST_ROW)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    row_next   = row_reg + 3'd1;
                    state_next = S_DRAW_A;
                end
            end

            S_DRAW_C:
            begin
                dot_we    = 1'b1;
                dot_waddr = dot_addr(row_reg, byte_inc);
                dot_wdata = (dot_rdata & keep_mask) | draw_spread[7:0];
                if (row_reg == dmtb_pkg::LAST_ROW)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    row_next   = row_reg + 3'd1;
                    state_next = S_DRAW_A;
                end
            end

            S_ROT:
            begin
                if (col_reg < row_bytes)
                begin
                    arr_valid_next = 1'b1;
                    col_next       = col_reg + 6'd1;
                end
                else
                begin
                    fin_valid_next = 1'b1;
                    col_next       = 6'd0;
                    if (row_reg == dmtb_pkg::LAST_ROW)
                    begin
                        state_next = S_ROT_FIN;
                    end
                    else
                    begin
                        row_next = row_reg + 3'd1;
                    end
                end
            end

            S_ROT_FIN:
            begin
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            clr_cmd_reg   <= 1'b0;
            arr_valid_reg <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_cmd_reg   <= clr_cmd_next;
            arr_valid_reg <= arr_valid_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        code_reg     <= code_next;
        byte_reg     <= byte_next;
        bit_reg      <= bit_next;
        shift_reg    <= shift_next;
        left_reg     <= left_next;
        glyph_reg    <= glyph_next;
        arr_col_reg  <= arr_col_next;
        arr_row_reg  <= arr_row_next;
        fin_row_reg  <= fin_row_next;
        first_reg    <= first_next;
        prev_reg     <= prev_next;
        res_data_reg <= res_data_next;
        res_ign_reg  <= res_ign_next;
    end

    assign idle          = (state_reg == S_IDLE);
    assign res_valid     = (state_reg == S_RESULT);
    assign res.read_data = res_data_reg;
    assign res.ignored   = res_ign_reg;

endmodule

[hw/rtl/dot_matrix_text_buffer_core.sv]
// ----------------------------------------------------------------------------
// Dot-matrix text buffer core
// Eight-row one-bit-per-dot frame buffer with an 8x8 font store, glyph
// drawing, row rotation, clearing and byte read-back.
// ----------------------------------------------------------------------------
// One command is worked at a time; every command returns exactly one result
// beat, which leaves through an output register, so the next command is taken
// while that beat waits. The dot memory has a single read and a single write
// port; a glyph draw and a rotate pass each byte they touch through it as a
// read-modify-write, and a clear writes zero to every byte. After reset the dot
// memory is swept to zero with in_ready low; the row_bytes register may be
// written during that sweep and at any other time the core is idle.
// ----------------------------------------------------------------------------
module dot_matrix_text_buffer_core #(
    parameter int MAX_ROW_BYTES = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [5:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] command,
    input  logic [7:0] dot_column,
    input  logic [7:0] char_code,
    input  logic [2:0] row_index,
    input  logic [4:0] byte_index,
    input  logic [7:0] data_byte,
    input  logic [3:0] shift_amount,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       ignored
);

    localparam int DOT_DEPTH  = dmtb_pkg::ROW_COUNT * MAX_ROW_BYTES;
    localparam int DOT_ADDR_W = $clog2(DOT_DEPTH);
    localparam logic [5:0] ROW_BYTES_MAX  = 6'(MAX_ROW_BYTES);
    localparam logic [5:0] ROW_BYTES_INIT =
        6'((MAX_ROW_BYTES < dmtb_pkg::ROW_BYTES_RESET) ? MAX_ROW_BYTES
                                                       : dmtb_pkg::ROW_BYTES_RESET);

    logic [5:0] row_bytes_reg, row_bytes_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] read_data_reg;
    logic       ignored_reg;

    dmtb_pkg::cmd_t cmd;
    dmtb_pkg::res_t eng_res;
    logic           eng_idle;
    logic           eng_res_valid;
    logic           eng_res_ready;

    logic                             font_we;
    logic [dmtb_pkg::FONT_ADDR_W-1:0] font_waddr;
    logic [7:0]                       font_wdata;
    logic [dmtb_pkg::FONT_ADDR_W-1:0] font_raddr;
    logic [7:0]                       font_rdata;
    logic                             dot_we;
    logic [DOT_ADDR_W-1:0]            dot_waddr;
    logic [7:0]                       dot_wdata;
    logic [DOT_ADDR_W-1:0]            dot_raddr;
    logic [7:0]                       dot_rdata;

    assign cmd.command      = command;
    assign cmd.dot_column   = dot_column;
    assign cmd.char_code    = char_code;
    assign cmd.row_index    = row_index;
    assign cmd.byte_index   = byte_index;
    assign cmd.data_byte    = data_byte;
    assign cmd.shift_amount = shift_amount;

    // clamp the width register into 1..MAX_ROW_BYTES
    always_comb
    begin
        row_bytes_next = row_bytes_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == 6'd0)
            begin
                row_bytes_next = 6'd1;
            end
            else if (cfg_wdata > ROW_BYTES_MAX)
            begin
                row_bytes_next = ROW_BYTES_MAX;
            end
            else
            begin
                row_bytes_next = cfg_wdata;
            end
        end
    end

    assign eng_res_ready  = !out_valid_reg || out_ready;
    assign out_valid_next = eng_res_valid || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= ROW_BYTES_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_bytes_reg <= row_bytes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_res_valid && eng_res_ready)
        begin
            read_data_reg <= eng_res.read_data;
            ignored_reg   <= eng_res.ignored;
        end
    end

    dmtb_engine #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_valid),
        .cmd        (cmd),
        .idle       (eng_idle),
        .row_bytes  (row_bytes_reg),
        .font_we    (font_we),
        .font_waddr (font_waddr),
        .font_wdata (font_wdata),
        .font_raddr (font_raddr),
        .font_rdata (font_rdata),
        .dot_we     (dot_we),
        .dot_waddr  (dot_waddr),
        .dot_wdata  (dot_wdata),
        .dot_raddr  (dot_raddr),
        .dot_rdata  (dot_rdata),
        .res_valid  (eng_res_valid),
        .res        (eng_res),
        .res_ready  (eng_res_ready)
    );

    dmtb_ram #(
        .WIDTH (8),
        .DEPTH (dmtb_pkg::FONT_DEPTH)
    ) u_font_ram (
        .clk   (clk),
        .we    (font_we),
        .waddr (font_waddr),
        .wdata (font_wdata),
        .raddr (font_raddr),
        .rdata (font_rdata)
    );

    dmtb_ram #(
        .WIDTH (8),
        .DEPTH (DOT_DEPTH)
    ) u_dot_ram (
        .clk   (clk),
        .we    (dot_we),
        .waddr (dot_waddr),
        .wdata (dot_wdata),
        .raddr (dot_raddr),
        .rdata (dot_rdata)
    );

    assign in_ready  = eng_idle;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign ignored   = ignored_reg;

`ifndef SYNTHESIS
    a_idle_or_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(eng_idle && eng_res_valid))
        else $error("engine idle while holding a result");

    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(font_we && dot_we))
        else $error("font and dot memories written in the same cycle");

    a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ignored |-> read_data == 8'h00)
        else $error("ignored beat carries read data");

    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_bytes_reg != 6'd0 && row_bytes_reg <= ROW_BYTES_MAX)
        else $error("row width register out of range");
`endif

endmodule

[dv/tb_dot_matrix_text_buffer_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dot-matrix text buffer core testbench
// Sends font loads, glyph draws, row rotations, clears and byte reads through
// the command channel and keeps its own image of the frame buffer and font.
// Every result beat is checked against the value that image predicts. Phases
// switch the row width and the amount of idling on both channels. One phase
// holds the result channel off for a long stretch so that the core backs up.
// ----------------------------------------------------------------------------
module tb_dot_matrix_text_buffer_core;

    localparam int MAX_ROW_BYTES = 32;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 1200;
    localparam int TAIL_CYCLES   = 300;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [7:0] QMARK_BYTE   = {1'b0, dmtb_pkg::QMARK_CODE};

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [5:0] cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] command;
    logic [7:0] dot_column;
    logic [7:0] char_code;
    logic [2:0] row_index;
    logic [4:0] byte_index;
    logic [7:0] data_byte;
    logic [3:0] shift_amount;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] read_data;
    logic       ignored;

    dot_matrix_text_buffer_core #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .dot_column  (dot_column),
        .char_code   (char_code),
        .row_index   (row_index),
        .byte_index  (byte_index),
        .data_byte   (data_byte),
        .shift_amount(shift_amount),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .ignored     (ignored)
    );

    // Buffer image, font image and row width as the core should hold them
    logic [7:0]  dot_image [dmtb_pkg::ROW_COUNT][MAX_ROW_BYTES];
    logic [7:0]  font_image [dmtb_pkg::FONT_DEPTH];
    int unsigned row_bytes_in_use;

    // Glyphs whose eight rows have all been loaded, known when queuing
    logic [7:0]  glyph_rows_loaded [dmtb_pkg::GLYPH_COUNT];
    logic [7:0]  drawable_glyphs [$];

    dmtb_pkg::cmd_t pending_commands [$];
    dmtb_pkg::res_t expected_results [$];
    dmtb_pkg::cmd_t offered;
    dmtb_pkg::res_t want;
    logic           next_valid;

    int unsigned sender_idle_pct;
    int unsigned recv_stall_pct;
    logic        hold_request;
    logic        hold_served;
    int unsigned hold_left;
    int unsigned cycle_count;
    int unsigned mismatch_count;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [2:0] rand_row();
        return 3'($urandom_range(7));
    endfunction

    function automatic logic [4:0] rand_bix();
        return 5'($urandom_range(31));
    endfunction

    function automatic logic [3:0] rand_shift();
        return 4'($urandom_range(15));
    endfunction

    function automatic dmtb_pkg::res_t apply_command(dmtb_pkg::cmd_t c);
        dmtb_pkg::res_t r;
        int unsigned    n;
        logic [4:0]     byte_pos;
        logic [2:0]     bit_pos;
        logic [6:0]     code;
        logic [7:0]     g;
        logic [7:0]     keep;
        logic [15:0]    pair;
        logic [7:0]     old_row [MAX_ROW_BYTES];
        r = '0;
        n = row_bytes_in_use;
        case (c.command)
            dmtb_pkg::CMD_LOAD_FONT:
            begin
                if (c.char_code[7])
                    r.ignored = 1'b1;
                else
                    font_image[{c.char_code[6:0], c.row_index}] = c.data_byte;
            end
            dmtb_pkg::CMD_DRAW:
            begin
                if (c.dot_column >= n * 8)
                    r.ignored = 1'b1;
                else
                begin
                    byte_pos = c.dot_column[7:3];
                    bit_pos  = c.dot_column[2:0];
                    keep     = 8'hFF >> bit_pos;
                    code     = c.char_code[7] ? dmtb_pkg::QMARK_CODE : c.char_code[6:0];
                    for (int row = 0; row < dmtb_pkg::ROW_COUNT; row++)
                    begin
                        g = font_image[{code, 3'(row)}];
                        if (bit_pos == 3'd0)
                            dot_image[row][byte_pos] = g;
                        else
                        begin
                            dot_image[row][byte_pos] =
                                (dot_image[row][byte_pos] & ~keep) | (g >> bit_pos);
                            if (byte_pos + 1 < n)
                                dot_image[row][byte_pos + 1] =
                                    (dot_image[row][byte_pos + 1] & keep) |
                                    (g << (8 - bit_pos));
                        end
                    end
                end
            end
            dmtb_pkg::CMD_ROT_LEFT, dmtb_pkg::CMD_ROT_RIGHT:
            begin
                if (c.shift_amount == 4'd0 || c.shift_amount > dmtb_pkg::SHIFT_MAX)
                    r.ignored = 1'b1;
                else
                begin
                    for (int row = 0; row < dmtb_pkg::ROW_COUNT; row++)
                    begin
                        old_row = dot_image[row];
                        for (int i = 0; i < n; i++)
                        begin
                            if (c.command == dmtb_pkg::CMD_ROT_LEFT)
                            begin
                                pair = {old_row[i], old_row[(i + 1) % n]} << c.shift_amount;
                                dot_image[row][i] = pair[15:8];
                            end
                            else
                            begin
                                pair = {old_row[(i + n - 1) % n], old_row[i]} >> c.shift_amount;
                                dot_image[row][i] = pair[7:0];
                            end
                        end
                    end
                end
            end
            dmtb_pkg::CMD_CLEAR:
            begin
                for (int row = 0; row < dmtb_pkg::ROW_COUNT; row++)
                    for (int i = 0; i < MAX_ROW_BYTES; i++)
                        dot_image[row][i] = 8'h00;
            end
            dmtb_pkg::CMD_READ:
            begin
                if (c.byte_index >= n)
                    r.ignored = 1'b1;
                else
                    r.read_data = dot_image[c.row_index][c.byte_index];
            end
            default:
                r.ignored = 1'b1;
        endcase
        return r;
    endfunction

    function automatic void queue_command(logic [2:0] op, logic [7:0] col, logic [7:0] code,
                                          logic [2:0] row, logic [4:0] bix, logic [7:0] data,
                                          logic [3:0] shift);
        dmtb_pkg::cmd_t c;
        c.command      = op;
        c.dot_column   = col;
        c.char_code    = code;
        c.row_index    = row;
        c.byte_index   = bix;
        c.data_byte    = data;
        c.shift_amount = shift;
        pending_commands.push_back(c);
        if (op == dmtb_pkg::CMD_LOAD_FONT && code < dmtb_pkg::GLYPH_COUNT &&
            glyph_rows_loaded[code] != 8'hFF)
        begin
            glyph_rows_loaded[code][row] = 1'b1;
            if (glyph_rows_loaded[code] == 8'hFF)
                drawable_glyphs.push_back(code);
        end
    endfunction

    // Queue one random beat or a whole glyph load; return the beat count
    function automatic int unsigned queue_traffic();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  code;
        logic [7:0]  col;
        logic [4:0]  bix;
        logic [3:0]  shift;
        logic [2:0]  op;
        n    = row_bytes_in_use;
        pick = $urandom_range(99);
        col  = rand_byte();
        bix  = rand_bix();
        if (pick < 20)
        begin
            code = 8'($urandom_range(dmtb_pkg::GLYPH_COUNT - 1));
            for (int row = 0; row < dmtb_pkg::ROW_COUNT; row++)
                queue_command(dmtb_pkg::CMD_LOAD_FONT, rand_byte(), code, 3'(row),
                              rand_bix(), rand_byte(), rand_shift());
            return 8;
        end
        if (pick < 28)
        begin
            queue_command(dmtb_pkg::CMD_LOAD_FONT, col, rand_byte(), rand_row(), bix,
                          rand_byte(), rand_shift());
            return 1;
        end
        if (pick < 50)
        begin
            if ($urandom_range(99) < 80)
                col = 8'($urandom_range(n * 8 - 1));
            if (drawable_glyphs.size() == 0 || $urandom_range(99) < 25)
                code = 8'($urandom_range(255, 128));
            else
                code = drawable_glyphs[$urandom_range(drawable_glyphs.size() - 1)];
            queue_command(dmtb_pkg::CMD_DRAW, col, code, rand_row(), bix, rand_byte(),
                          rand_shift());
            return 1;
        end
        if (pick < 62)
        begin
            op    = $urandom_range(1) ? dmtb_pkg::CMD_ROT_LEFT : dmtb_pkg::CMD_ROT_RIGHT;
            shift = ($urandom_range(99) < 85) ? 4'($urandom_range(8, 1)) : rand_shift();
            queue_command(op, col, rand_byte(), rand_row(), bix, rand_byte(), shift);
            return 1;
        end
        if (pick < 65)
        begin
            queue_command(dmtb_pkg::CMD_CLEAR, col, rand_byte(), rand_row(), bix,
                          rand_byte(), rand_shift());
            return 1;
        end
        if (pick < 95)
        begin
            if ($urandom_range(99) < 85)
                bix = 5'($urandom_range(n - 1));
            queue_command(dmtb_pkg::CMD_READ, col, rand_byte(), rand_row(), bix,
                          rand_byte(), rand_shift());
            return 1;
        end
        op = $urandom_range(1) ? CMD_SPARE_LO : CMD_SPARE_HI;
        queue_command(op, col, rand_byte(), rand_row(), bix, rand_byte(), rand_shift());
        return 1;
    endfunction

    task automatic wait_for_idle();
        while (pending_commands.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned width, input int unsigned send_pct,
                             input int unsigned stall_pct, input int unsigned beat_total,
                             input bit directed, input bit hold_off);
        int unsigned queued;
        wait_for_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= width[5:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        row_bytes_in_use = (width == 0) ? 1 : (width > MAX_ROW_BYTES) ? MAX_ROW_BYTES : width;
        sender_idle_pct  = send_pct;
        recv_stall_pct   = stall_pct;
        if (hold_off)
            hold_request <= ~hold_request;
        if (directed)
        begin
            queue_command(dmtb_pkg::CMD_LOAD_FONT, '0, QMARK_BYTE, 3'd0, '0, 8'hFF, '0);
            queue_command(dmtb_pkg::CMD_LOAD_FONT, '0, QMARK_BYTE, 3'd1, '0, 8'h81, '0);
            queue_command(dmtb_pkg::CMD_LOAD_FONT, '0, QMARK_BYTE, 3'd2, '0, 8'h42, '0);
            queue_command(dmtb_pkg::CMD_LOAD_FONT, '0, QMARK_BYTE, 3'd3, '0, 8'h24, '0);
            queue_command(dmtb_pkg::CMD_LOAD_FONT, '0, QMARK_BYTE, 3'd4, '0, 8'h18, '0);
            queue_command(dmtb_pkg::CMD_LOAD_FONT, '0, QMARK_BYTE, 3'd5, '0, 8'h00, '0);
            queue_command(dmtb_pkg::CMD_LOAD_FONT, '0, QMARK_BYTE, 3'd6, '0, 8'hA5, '0);
            queue_command(dmtb_pkg::CMD_LOAD_FONT, '0, QMARK_BYTE, dmtb_pkg::LAST_ROW, '0,
                          8'h5A, '0);
            queue_command(dmtb_pkg::CMD_LOAD_FONT, '0, 8'd200, 3'd3, '0, 8'h77, '0);
            queue_command(dmtb_pkg::CMD_DRAW, '0, 8'd255, '0, '0, '0, '0);
            queue_command(dmtb_pkg::CMD_DRAW, 8'd61, QMARK_BYTE, '0, '0, '0, '0);
            queue_command(dmtb_pkg::CMD_DRAW, 8'd64, QMARK_BYTE, '0, '0, '0, '0);
            queue_command(dmtb_pkg::CMD_DRAW, 8'd3, 8'd130, '0, '0, '0, '0);
            queue_command(dmtb_pkg::CMD_ROT_LEFT, '0, '0, '0, '0, '0, 4'd1);
            queue_command(dmtb_pkg::CMD_ROT_RIGHT, '0, '0, '0, '0, '0, dmtb_pkg::SHIFT_MAX);
            queue_command(dmtb_pkg::CMD_ROT_LEFT, '0, '0, '0, '0, '0, dmtb_pkg::SHIFT_MAX);
            queue_command(dmtb_pkg::CMD_ROT_LEFT, '0, '0, '0, '0, '0, 4'd0);
            queue_command(dmtb_pkg::CMD_ROT_RIGHT, '0, '0, '0, '0, '0, 4'd9);
            queue_command(dmtb_pkg::CMD_READ, '0, '0, '0, '0, '0, '0);
            queue_command(dmtb_pkg::CMD_READ, '0, '0, dmtb_pkg::LAST_ROW, 5'd7, '0, '0);
            queue_command(dmtb_pkg::CMD_READ, '0, '0, '0, 5'd8, '0, '0);
            queue_command(CMD_SPARE_LO, '0, '0, '0, '0, '0, '0);
            queue_command(CMD_SPARE_HI, 8'hFF, 8'hFF, 3'd7, 5'd31, 8'hFF, 4'hF);
            queue_command(dmtb_pkg::CMD_CLEAR, '0, '0, '0, '0, '0, '0);
            queue_command(dmtb_pkg::CMD_READ, '0, '0, 3'd3, 5'd2, '0, '0);
        end
        queued = 0;
        while (queued < beat_total)
            queued += queue_traffic();
    endtask

    // Driver: predict each accepted beat, then offer the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_results.push_back(apply_command(offered));
            next_valid = in_valid && !in_ready;
            if (!next_valid && pending_commands.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct)
            begin
                offered      = pending_commands.pop_front();
                next_valid   = 1'b1;
                command      <= offered.command;
                dot_column   <= offered.dot_column;
                char_code    <= offered.char_code;
                row_index    <= offered.row_index;
                byte_index   <= offered.byte_index;
                data_byte    <= offered.data_byte;
                shift_amount <= offered.shift_amount;
            end
            in_valid <= next_valid;
        end
    end

    always @(posedge clk)
    begin
        if (hold_request != hold_served)
        begin
            hold_served <= hold_request;
            hold_left   <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
        out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);

    // Monitor: compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: read_data %0h ignored %0b",
                       read_data, ignored);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (read_data !== want.read_data)
                begin
                    $error("read_data: expected %0h, got %0h", want.read_data, read_data);
                    mismatch_count++;
                end
                if (ignored !== want.ignored)
                begin
                    $error("ignored: expected %0b, got %0b", want.ignored, ignored);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_valid         = 1'b0;
        command          = '0;
        dot_column       = '0;
        char_code        = '0;
        row_index        = '0;
        byte_index       = '0;
        data_byte        = '0;
        shift_amount     = '0;
        out_ready        = 1'b0;
        hold_request     = 1'b0;
        hold_served      = 1'b0;
        hold_left        = 0;
        cycle_count      = 0;
        mismatch_count   = 0;
        sender_idle_pct  = 0;
        recv_stall_pct   = 0;
        row_bytes_in_use = dmtb_pkg::ROW_BYTES_RESET;
        for (int row = 0; row < dmtb_pkg::ROW_COUNT; row++)
            for (int i = 0; i < MAX_ROW_BYTES; i++)
                dot_image[row][i] = 8'h00;
        for (int g = 0; g < dmtb_pkg::GLYPH_COUNT; g++)
            glyph_rows_loaded[g] = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        run_phase(8, 0, 0, 90, 1'b1, 1'b0);
        run_phase(32, 69, 0, 110, 1'b0, 1'b0);
        run_phase(1, 0, 69, 90, 1'b0, 1'b0);
        run_phase(0, 23, 23, 60, 1'b0, 1'b0);
        run_phase(63, 0, 0, 110, 1'b0, 1'b1);
        run_phase($urandom_range(31, 2), 23, 23, 90, 1'b0, 1'b0);
        run_phase($urandom_range(32, 1), 69, 0, 75, 1'b0, 1'b0);

        wait_for_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/dmtb_pkg.sv
hw/rtl/dmtb_ram.sv
hw/rtl/dmtb_engine.sv
hw/rtl/dot_matrix_text_buffer_core.sv
dv/tb_dot_matrix_text_buffer_core.sv
